[sv/pdtm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtm_pkg
// Shared types and constants of the pwm duty temperature meter.
// ----------------------------------------------------------------------------
package pdtm_pkg;

  localparam int TIMER_BITS = 16;                 // capture timer width, 8..32
  localparam int SCALE_W    = 16;
  localparam int INTV_W     = 8;
  localparam int READ_W     = 16;
  localparam int PROD_W     = TIMER_BITS + SCALE_W;
  localparam int DCNT_W     = $clog2(PROD_W + 1);

  localparam logic [SCALE_W-1:0] FULL_SCALE_RST = SCALE_W'(11000);
  localparam logic [INTV_W-1:0]  REFRESH_RST    = INTV_W'(20);
  localparam logic [READ_W-1:0]  READ_MAX       = {READ_W{1'b1}};

  typedef logic [TIMER_BITS-1:0] tval_t;

  // configuration register indexes
  localparam logic CFG_FULL_SCALE = 1'b0;
  localparam logic CFG_REFRESH    = 1'b1;

  // request codes
  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef enum logic [1:0] {
    PH_RISE = 2'd0,
    PH_FALL = 2'd1,
    PH_NEXT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/pdtm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtm_if
// Valid/ready channels for capture/tick requests and meter results.
// ----------------------------------------------------------------------------
interface pdtm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] capture_time;

  modport source (output valid, output req_type, output capture_time, input ready);
  modport sink   (input valid, input req_type, input capture_time, output ready);
endinterface

interface pdtm_out_if;
  logic        valid;
  logic        ready;
  logic        arm_rising;
  logic [15:0] reading_centi;
  logic        reading_updated;
  logic        refresh_strobe;

  modport source (output valid, output arm_rising, output reading_centi,
                  output reading_updated, output refresh_strobe, input ready);
  modport sink   (input valid, input arm_rising, input reading_centi,
                  input reading_updated, input refresh_strobe, output ready);
endinterface

[sv/pdtm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtm_div
// Restoring divider, one quotient bit per cycle, PROD_W quotient bits per divide.
// ----------------------------------------------------------------------------
module pdtm_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [pdtm_pkg::PROD_W-1:0]     dividend,
  input  pdtm_pkg::tval_t         divisor,
  output logic [pdtm_pkg::PROD_W-1:0]     quotient,
  output pdtm_pkg::div_stat_t     stat
);
  import pdtm_pkg::*;

  tval_t                 rem_r, rem_nxt;
  logic [PROD_W-1:0]     quo_r, quo_nxt;
  tval_t                 dvs_r, dvs_nxt;
  logic [DCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [TIMER_BITS:0]   trial;
  logic                  fits;

  always_comb begin
    trial    = {rem_r, quo_r[PROD_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = DCNT_W'(PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shared subtract/compare step, the remainder stays below the divisor
      rem_nxt = fits ? tval_t'(trial - {1'b0, dvs_r}) : trial[TIMER_BITS-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[sv/pwm_duty_temperature_meter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_duty_temperature_meter_core
// PWM duty meter: edge capture tracking, scaled duty reading, refresh strobe.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries transactions of two kinds: a capture event with the timer
//   value latched at the armed edge, or a periodic tick. Every transaction
//   gives exactly one result on out_ch: the edge to arm next, the held
//   reading, whether this tick updated it, and the display refresh strobe.
//   cfg_we/cfg_index/cfg_data write full scale (index 0) and the refresh
//   interval (index 1); write only while the block is idle.
// Processing:
//   a capture event or a tick with nothing to compute goes straight from
//   acceptance to the result stage and then to the output register. A tick
//   that finishes a capture with a nonzero period goes through one multiply
//   step, then the restoring divider producing one quotient bit per
//   cycle. in_ch.ready is low while a transaction is being worked on.
// Reset: reset clears phase, timestamps, reading and tick count and restores
//   full scale 11000 and refresh interval 20. No clearing pass is needed.
// Stall: a result waits in the output register; the next transaction may
//   be accepted and worked on but its result holds until the register frees.
// ----------------------------------------------------------------------------
module pwm_duty_temperature_meter_core (
  input  logic        clk,
  input  logic        rst_n,
  pdtm_in_if.sink     in_ch,
  pdtm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import pdtm_pkg::*;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  tval_t                rise_r, rise_nxt;
  tval_t                fall_r, fall_nxt;
  tval_t                next_r, next_nxt;
  logic                 cdone_r, cdone_nxt;
  logic [READ_W-1:0]    reading_r, reading_nxt;
  logic [INTV_W-1:0]    tick_r, tick_nxt;
  logic [SCALE_W-1:0]   scale_r, scale_nxt;
  logic [INTV_W-1:0]    intv_r, intv_nxt;

  tval_t                high_r, high_nxt;
  tval_t                per_r, per_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;

  logic                 res_arm_r, res_arm_nxt;
  logic                 res_upd_r, res_upd_nxt;
  logic                 res_strb_r, res_strb_nxt;

  logic                 ov_r, ov_nxt;
  logic                 oarm_r, oarm_nxt;
  logic [READ_W-1:0]    oread_r, oread_nxt;
  logic                 oupd_r, oupd_nxt;
  logic                 ostrb_r, ostrb_nxt;

  logic                 accept;
  tval_t                ctime;
  logic [INTV_W:0]      tick_inc;
  logic                 div_start;
  logic [PROD_W-1:0]    quotient;
  div_stat_t            div_stat;
  logic                 out_free;

  pdtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (per_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && (state_r == ST_IDLE);
  assign ctime       = tval_t'(in_ch.capture_time);
  assign tick_inc    = {1'b0, tick_r} + 1'b1;
  assign out_free    = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    rise_nxt     = rise_r;
    fall_nxt     = fall_r;
    next_nxt     = next_r;
    cdone_nxt    = cdone_r;
    reading_nxt  = reading_r;
    tick_nxt     = tick_r;
    scale_nxt    = scale_r;
    intv_nxt     = intv_r;
    high_nxt     = high_r;
    per_nxt      = per_r;
    prod_nxt     = prod_r;
    res_arm_nxt  = res_arm_r;
    res_upd_nxt  = res_upd_r;
    res_strb_nxt = res_strb_r;
    ov_nxt       = ov_r;
    oarm_nxt     = oarm_r;
    oread_nxt    = oread_r;
    oupd_nxt     = oupd_r;
    ostrb_nxt    = ostrb_r;
    div_start    = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_SCALE: scale_nxt = cfg_data[SCALE_W-1:0];
        CFG_REFRESH:    intv_nxt  = cfg_data[INTV_W-1:0];
        default:        ;
      endcase
    end

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_upd_nxt  = 1'b0;
          res_strb_nxt = 1'b0;
          state_nxt    = ST_DONE;
          if (in_ch.req_type == REQ_CAPTURE) begin
            case (phase_r)
              PH_FALL: begin
                fall_nxt  = ctime;
                phase_nxt = PH_NEXT;
              end
              PH_NEXT: begin
                next_nxt  = ctime;
                phase_nxt = PH_RISE;
                cdone_nxt = 1'b1;
              end
              default: begin
                rise_nxt  = ctime;
                phase_nxt = PH_FALL;
              end
            endcase
          end else begin
            // interval lowered below the count also strobes here
            if (tick_inc >= {1'b0, intv_r}) begin
              tick_nxt     = '0;
              res_strb_nxt = 1'b1;
            end else begin
              tick_nxt = tick_inc[INTV_W-1:0];
            end
            if (cdone_r) begin
              cdone_nxt = 1'b0;
              high_nxt  = fall_r - rise_r;
              per_nxt   = next_r - rise_r;
              // zero period leaves the reading as it is
              if ((next_r - rise_r) != '0) state_nxt = ST_MUL;
            end
          end
          res_arm_nxt = (phase_nxt != PH_FALL);
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(high_r) * PROD_W'(scale_r);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_stat.busy && !div_stat.done) begin
          div_start = 1'b1;
        end else if (div_stat.done) begin
          reading_nxt = (|quotient[PROD_W-1:READ_W]) ? READ_MAX
                                                     : quotient[READ_W-1:0];
          res_upd_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oarm_nxt  = res_arm_r;
          oread_nxt = reading_r;
          oupd_nxt  = res_upd_r;
          ostrb_nxt = res_strb_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // the divider is started only once: its busy flag rises the cycle after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      phase_r   <= PH_RISE;
      rise_r    <= '0;
      fall_r    <= '0;
      next_r    <= '0;
      cdone_r   <= 1'b0;
      reading_r <= '0;
      tick_r    <= '0;
      scale_r   <= FULL_SCALE_RST;
      intv_r    <= REFRESH_RST;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      rise_r    <= rise_nxt;
      fall_r    <= fall_nxt;
      next_r    <= next_nxt;
      cdone_r   <= cdone_nxt;
      reading_r <= reading_nxt;
      tick_r    <= tick_nxt;
      scale_r   <= scale_nxt;
      intv_r    <= intv_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    high_r     <= high_nxt;
    per_r      <= per_nxt;
    prod_r     <= prod_nxt;
    res_arm_r  <= res_arm_nxt;
    res_upd_r  <= res_upd_nxt;
    res_strb_r <= res_strb_nxt;
    oarm_r     <= oarm_nxt;
    oread_r    <= oread_nxt;
    oupd_r     <= oupd_nxt;
    ostrb_r    <= ostrb_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.arm_rising      = oarm_r;
  assign out_ch.reading_centi   = oread_r;
  assign out_ch.reading_updated = oupd_r;
  assign out_ch.refresh_strobe  = ostrb_r;

endmodule

[dv/pdtm_meter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtm_meter_checker
// Watches the request, result and register ports of the duty meter. It keeps
// its own copy of the edge tracking, reading and tick count, queues the
// expected result of every request and compares each result field by field.
// ----------------------------------------------------------------------------
module pdtm_meter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_capture_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_arm_rising,
  input  logic [15:0] out_reading_centi,
  input  logic        out_reading_updated,
  input  logic        out_refresh_strobe,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          readings_owed
);
  import pdtm_pkg::*;

  typedef struct packed {
    logic              arm_rising;
    logic [READ_W-1:0] reading;
    logic              updated;
    logic              strobe;
  } meter_result_t;

  logic [SCALE_W-1:0] full_scale_q;
  logic [INTV_W-1:0]  interval_q;
  phase_t             edge_phase;
  tval_t              rise_ts;
  tval_t              fall_ts;
  tval_t              next_rise_ts;
  logic               set_complete;
  logic [READ_W-1:0]  reading_q;
  logic [INTV_W:0]    tick_cnt;

  meter_result_t expected_readings[$];

  // advances the meter by one request and returns the result it should give
  function automatic meter_result_t meter_step(logic req, tval_t stamp);
    meter_result_t     res;
    tval_t             high_t;
    tval_t             period_t;
    logic [PROD_W-1:0] quo;
    res = '0;
    if (req == REQ_CAPTURE) begin
      case (edge_phase)
        PH_FALL: begin
          fall_ts    = stamp;
          edge_phase = PH_NEXT;
        end
        PH_NEXT: begin
          next_rise_ts = stamp;
          edge_phase   = PH_RISE;
          set_complete = 1'b1;
        end
        default: begin
          rise_ts    = stamp;
          edge_phase = PH_FALL;
        end
      endcase
    end else begin
      if (set_complete) begin
        high_t       = fall_ts - rise_ts;
        period_t     = next_rise_ts - rise_ts;
        set_complete = 1'b0;
        // zero period leaves the old reading in place
        if (period_t != '0) begin
          quo = (PROD_W'(high_t) * PROD_W'(full_scale_q)) / PROD_W'(period_t);
          reading_q   = (quo > PROD_W'(READ_MAX)) ? READ_MAX : READ_W'(quo);
          res.updated = 1'b1;
        end
      end
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= {1'b0, interval_q}) begin
        tick_cnt   = '0;
        res.strobe = 1'b1;
      end
    end
    res.arm_rising = (edge_phase != PH_FALL);
    res.reading    = reading_q;
    return res;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    meter_result_t want;
    if (!rst_n) begin
      full_scale_q  = FULL_SCALE_RST;
      interval_q    = REFRESH_RST;
      edge_phase    = PH_RISE;
      rise_ts       = '0;
      fall_ts       = '0;
      next_rise_ts  = '0;
      set_complete  = 1'b0;
      reading_q     = '0;
      tick_cnt      = '0;
      fail_count    = 0;
      expected_readings.delete();
    end else begin
      // results never come out on the edge their request goes in
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: result transaction with none expected, actual reading %0d",
                   $time, out_reading_centi);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("arm_rising", want.arm_rising, out_arm_rising);
          check_field("reading_centi", want.reading, out_reading_centi);
          check_field("reading_updated", want.updated, out_reading_updated);
          check_field("refresh_strobe", want.strobe, out_refresh_strobe);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_FULL_SCALE) begin
          full_scale_q = cfg_data;
        end else begin
          interval_q = cfg_data[INTV_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        expected_readings.push_back(meter_step(in_req_type, tval_t'(in_capture_time)));
      end
    end
    readings_owed = expected_readings.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Duty meter testbench: directed edge sets (wrap, zero period, saturation,
// partial captures) then randomized PWM frames and noise over several
// full scale / refresh interval settings, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import pdtm_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = PROD_W + 8;
  localparam int NUM_SETTINGS = 6;
  localparam int ITEMS_PER_SETTING = 115;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int readings_owed;
  int items_sent;
  bit gap_on;
  bit stall_on;

  pdtm_in_if  in_ch ();
  pdtm_out_if out_ch ();

  pwm_duty_temperature_meter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pdtm_meter_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_req_type         (in_ch.req_type),
    .in_capture_time     (in_ch.capture_time),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_arm_rising      (out_ch.arm_rising),
    .out_reading_centi   (out_ch.reading_centi),
    .out_reading_updated (out_ch.reading_updated),
    .out_refresh_strobe  (out_ch.refresh_strobe),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .readings_owed       (readings_owed)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = stall_on ? $urandom_range(0, 8) : 0;
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // one request transaction; returns at the falling edge after acceptance
  task automatic send_request(logic req, logic [15:0] stamp);
    int gap;
    gap = gap_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= req;
    in_ch.capture_time <= stamp;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_request(REQ_TICK, 16'($urandom));
  endtask

  // rising edge, falling edge and next rising edge of one PWM period
  task automatic send_pwm_frame(tval_t rise, tval_t high, tval_t period);
    send_request(REQ_CAPTURE, rise);
    send_request(REQ_CAPTURE, tval_t'(rise + high));
    send_request(REQ_CAPTURE, tval_t'(rise + period));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (readings_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(logic [15:0] scale, logic [7:0] interval);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FULL_SCALE;
    cfg_data  <= scale;
    @(negedge clk);
    cfg_index <= CFG_REFRESH;
    cfg_data  <= {8'd0, interval};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_frame();
    tval_t rise;
    tval_t high;
    tval_t period;
    rise = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        period = '0;
        high   = $urandom;
      end
      1: begin
        // high time may exceed the period
        period = $urandom;
        high   = $urandom;
      end
      2: begin
        period = $urandom_range(1, 64);
        high   = $urandom_range(0, period);
      end
      default: begin
        period = $urandom_range(1, 65535);
        high   = $urandom_range(0, period);
      end
    endcase
    send_pwm_frame(rise, high, period);
    repeat ($urandom_range(1, 3)) send_tick();
  endtask

  initial begin
    logic [15:0] scales [NUM_SETTINGS];
    logic [7:0]  intervals [NUM_SETTINGS];
    int          target;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_CAPTURE;
    in_ch.capture_time = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_FULL_SCALE;
    cfg_data           = '0;
    items_sent         = 0;
    gap_on             = 1'b1;
    stall_on           = 1'b1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings
    send_tick();
    send_pwm_frame(16'd100, 16'd500, 16'd1000);
    send_tick();
    // timestamps wrapping through zero
    send_pwm_frame(16'hFF00, 16'h0110, 16'h0200);
    send_tick();
    // zero period keeps the reading
    send_pwm_frame(16'd5, 16'd4, 16'd0);
    send_tick();
    // saturated reading
    send_pwm_frame(16'd0, 16'hFFFF, 16'd1);
    send_tick();
    // tick while waiting for the falling edge computes nothing
    send_request(REQ_CAPTURE, 16'hFFFF);
    send_tick();
    send_request(REQ_CAPTURE, 16'h0000);
    send_request(REQ_CAPTURE, 16'hFFFF);
    send_tick();
    wait_idle();

    scales    = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd11000, 16'($urandom)};
    intervals = '{8'd1, 8'd255, 8'd2, 8'd0, 8'($urandom), 8'd20};
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_settings(scales[s], intervals[s]);
      gap_on   = (s != 0) && ($urandom_range(0, 3) != 0);
      stall_on = (s != 0) && ($urandom_range(0, 3) != 0);
      target   = items_sent + ITEMS_PER_SETTING;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          send_random_frame();
        end else begin
          send_request(1'($urandom), 16'($urandom));
        end
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
